FILE: rtl/htfr_pkg.sv
// Shared types and constants for the header/tail frame receiver.
// No dependencies; imported by every module of the block.
package htfr_pkg;

    localparam int DEF_MAX_FRAME = 64;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'd1;

    localparam logic [BYTE_W-1:0] START_RESET = 8'hFE;
    localparam logic [BYTE_W-1:0] END_RESET   = 8'hFD;

    // Controller to datapath
    typedef struct packed {
        logic open;   // header seen while hunting: restart the store
        logic store;  // byte inside a frame: append to the store
        logic drain;  // read the finished frame out
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rx_is_start;
        logic rx_is_end;
        logic full_next;  // the byte being stored fills the last slot
        logic rd_done;    // the final read of the frame issues this cycle
    } t_sts;

endpackage

FILE: rtl/htfr_ctrl.sv
// Controller state machine of the frame receiver: hunt, collect, drain.
// Depends on htfr_pkg for the command and status structs.
module htfr_ctrl
    import htfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    localparam logic [1:0] ST_HUNT  = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state == ST_DRAIN);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd.open  = 1'b0;
        o_cmd.store = 1'b0;
        o_cmd.drain = 1'b0;
        unique case (r_state)
            ST_HUNT: begin
                if (accept && i_sts.rx_is_start) begin
                    o_cmd.open = 1'b1;
                    n_state    = ST_FRAME;
                end
            end
            ST_FRAME: begin
                if (accept) begin
                    o_cmd.store = 1'b1;
                    if (i_sts.rx_is_end) begin
                        n_state = ST_DRAIN;
                    end else if (i_sts.full_next) begin
                        // drop the frame silently
                        n_state = ST_HUNT;
                    end
                end
            end
            ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_sts.rd_done) begin
                    n_state = ST_HUNT;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/htfr_dp.sv
// Datapath of the frame receiver: config registers, frame store memory,
// fill count, read pointer and output register. Depends on htfr_pkg.
module htfr_dp
    import htfr_pkg::*;
#(
    parameter int MAX_FRAME = DEF_MAX_FRAME
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_is_code,
    output logic                 o_last
);

    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [BYTE_W-1:0] r_cfg_start;
    logic [BYTE_W-1:0] r_cfg_end;
    logic [CW-1:0]     r_fill;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     r_last_addr;
    logic [BYTE_W-1:0] r_mem [MAX_FRAME];

    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_code;
    logic              r_rd_last;
    logic              r_rd_vld;

    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_code;
    logic              r_out_last;
    logic              r_out_vld;

    logic rd_en;
    logic load_out;

    assign o_sts.rx_is_start = (i_rx_byte == r_cfg_start);
    assign o_sts.rx_is_end   = (i_rx_byte == r_cfg_end);
    assign o_sts.full_next   = (r_fill == CW'(MAX_FRAME - 1));
    assign o_sts.rd_done     = rd_en && (r_rd_ptr == r_last_addr);

    assign load_out = r_rd_vld && (!r_out_vld || !i_out_stall);
    assign rd_en    = i_cmd.drain && (!r_rd_vld || load_out);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= START_RESET;
            r_cfg_end   <= END_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START: r_cfg_start <= i_cfg_data;
                CFG_END:   r_cfg_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // frame store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.open) begin
            r_mem[0] <= i_rx_byte;
        end else if (i_cmd.store) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
            r_rd_code <= (r_rd_ptr == AW'(1));
            r_rd_last <= (r_rd_ptr == r_last_addr);
        end
    end

    // fill count and read window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.open) begin
            r_fill <= CW'(1);
        end else if (i_cmd.store) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && o_sts.rx_is_end) begin
            // code sits at slot 1; payload runs up to the slot before the tail
            r_rd_ptr <= AW'(1);
            if (r_fill <= CW'(2)) begin
                r_last_addr <= AW'(1);
            end else begin
                r_last_addr <= r_fill[AW-1:0] - AW'(1);
            end
        end else if (rd_en) begin
            r_rd_ptr <= r_rd_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (rd_en) begin
            r_rd_vld <= 1'b1;
        end else if (load_out) begin
            r_rd_vld <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_byte <= r_rd_data;
            r_out_code <= r_rd_code;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;
    assign o_is_code   = r_out_code;
    assign o_last      = r_out_last;

endmodule

FILE: rtl/header_tail_frame_receiver.sv
// Top level of the header/tail frame receiver (receive-side deframer).
// Depends on htfr_pkg, htfr_ctrl and htfr_dp.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | in        | i_in_valid / o_in_stall    | i_rx_byte
//  out     | out       | o_out_valid / i_out_stall  | o_out_byte, o_is_code, o_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One received byte is taken per cycle while hunting or collecting a frame.
// On a tail byte the input stalls while the frame store is read out: the single
// memory read port sets the pace, and any stall on the output side adds to it.
// Results leave through an output register fed by a registered memory read,
// so the next frame's bytes are taken while the final result still waits.
// Reset is synchronous and clears control state and the config registers;
// the frame store is not cleared, since only slots written in the current
// frame are ever read.
module header_tail_frame_receiver
    import htfr_pkg::*;
#(
    parameter int MAX_FRAME = DEF_MAX_FRAME
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // received bytes
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    // frame results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_out_byte,
    output logic                 o_is_code,
    output logic                 o_last,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // config registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    htfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    htfr_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_rx_byte),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_is_code   (o_is_code),
        .o_last      (o_last)
    );

endmodule

FILE: rtl/htfr_checker.sv
// Port-level checks for the header/tail frame receiver, bound to the top level.
// Depends on htfr_pkg and header_tail_frame_receiver.
module htfr_checker
    import htfr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [BYTE_W-1:0] o_out_byte,
    input logic              o_is_code,
    input logic              o_last
);

    logic r_mid;  // inside a run: the previous result transfer was not last

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            r_mid <= !o_last;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_is_code) && $stable(o_last))
        else $error("stalled result changed");

    a_run_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_mid |-> o_is_code)
        else $error("run does not open with the code");

    a_run_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_mid |-> !o_is_code)
        else $error("code inside a run");

endmodule

bind header_tail_frame_receiver htfr_checker u_htfr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_is_code   (o_is_code),
    .o_last      (o_last)
);
